>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the lottery scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/lsc_pkg.sv
// Shared constants, codes and control structures of the lottery scheduler.
`timescale 1ns / 1ps

package lsc_pkg;

   localparam int MAX_JOBS   = 16;
   localparam int SLOT_W     = 4;
   localparam int BURST_W    = 16;
   localparam int TICKET_W   = 10;
   localparam int RND_W      = 16;
   localparam int TIME_W     = 32;
   localparam int PC_W       = 5;
   localparam int IDX_W      = $clog2(MAX_JOBS);
   localparam int CNT_W      = $clog2(MAX_JOBS + 1);
   localparam int NCMP_W     = (PC_W > CNT_W) ? PC_W : CNT_W;
   localparam int TOTAL_W    = $clog2(MAX_JOBS * ((1 << TICKET_W) - 1) + 1);
   localparam int DIVCNT_W   = $clog2(RND_W);
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 104;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_DRAW = 1'b1;

   typedef struct packed {
      logic capture;
      logic load_write;
      logic sum_step;
      logic div_init;
      logic div_step;
      logic scan_step;
      logic win_update;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic mode_draw;
      logic idx_end;
      logic total_zero;
      logic div_last;
      logic scan_hit;
   } status_type;

endpackage

>>> sv/lsc_ctrl.sv
// Sequencer of the lottery scheduler: steps one item through the table load, or through sum, divide, scan and update.
`timescale 1ns / 1ps

module lsc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  lsc_pkg::status_type status,
   output lsc_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_SUM    = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_SCAN   = 3'd4;
   localparam logic [2:0] ST_UPDATE = 3'd5;
   localparam logic [2:0] ST_RESULT = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SUM;
            end
         end
         ST_LOAD: begin
            cmd.load_write = 1'b1;
            state_in       = ST_RESULT;
         end
         ST_SUM: begin
            // The mode is known from the captured item by now.
            if (!status.mode_draw) begin
               state_in = ST_LOAD;
            end else if (status.idx_end) begin
               if (status.total_zero) begin
                  state_in = ST_RESULT;
               end else begin
                  cmd.div_init = 1'b1;
                  state_in     = ST_DIV;
               end
            end else begin
               cmd.sum_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.idx_end) begin
               state_in = ST_RESULT;
            end else if (status.scan_hit) begin
               state_in = ST_UPDATE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_UPDATE: begin
            cmd.win_update = 1'b1;
            state_in       = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> sv/lsc_dp.sv
// Datapath of the lottery scheduler: job table, ticket total, divider, scan and result register.
`timescale 1ns / 1ps

module lsc_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [lsc_pkg::PC_W-1:0]            csr_data,
   input  logic                                in_mode,
   input  logic [lsc_pkg::SLOT_W-1:0]          in_slot,
   input  logic [lsc_pkg::BURST_W-1:0]         in_burst,
   input  logic [lsc_pkg::TICKET_W-1:0]        in_tickets,
   input  logic [lsc_pkg::RND_W-1:0]           in_random_word,
   input  lsc_pkg::cmd_type                    cmd,
   output lsc_pkg::status_type                 status,
   output logic                                out_granted,
   output logic [lsc_pkg::SLOT_W-1:0]          out_winner,
   output logic                                out_finished,
   output logic [lsc_pkg::TIME_W-1:0]          out_completion_time,
   output logic [lsc_pkg::TIME_W-1:0]          out_waiting_time,
   output logic [lsc_pkg::TIME_W-1:0]          out_turnaround_time,
   output logic                                out_all_done
);

   logic [lsc_pkg::PC_W-1:0]     pc_ff;
   logic [lsc_pkg::TIME_W-1:0]   time_ff;
   logic [lsc_pkg::BURST_W-1:0]  remaining_ff [lsc_pkg::MAX_JOBS];
   logic [lsc_pkg::BURST_W-1:0]  original_ff  [lsc_pkg::MAX_JOBS];
   logic [lsc_pkg::TICKET_W-1:0] tickets_ff   [lsc_pkg::MAX_JOBS];
   logic [lsc_pkg::MAX_JOBS-1:0] active_ff;

   logic                         mode_ff;
   logic [lsc_pkg::SLOT_W-1:0]   slot_ff;
   logic [lsc_pkg::BURST_W-1:0]  burst_ff;
   logic [lsc_pkg::TICKET_W-1:0] load_tickets_ff;
   logic [lsc_pkg::RND_W-1:0]    quo_ff;
   logic [lsc_pkg::NCMP_W-1:0]   idx_ff;
   logic [lsc_pkg::TOTAL_W-1:0]  total_ff;
   logic [lsc_pkg::TOTAL_W-1:0]  rem_ff;
   logic [lsc_pkg::TOTAL_W-1:0]  rem_in;
   logic [lsc_pkg::DIVCNT_W-1:0] div_cnt_ff;
   logic                         grant_ff;
   logic                         fin_ff;

   logic [lsc_pkg::NCMP_W-1:0]   n_jobs;
   logic [lsc_pkg::MAX_JOBS-1:0] count_mask;
   logic [lsc_pkg::IDX_W-1:0]    cur;
   logic [lsc_pkg::IDX_W-1:0]    load_idx;
   logic                         slot_ok;
   logic [lsc_pkg::TOTAL_W:0]    trial;
   logic [lsc_pkg::TIME_W-1:0]   orig_ext;
   logic [lsc_pkg::TIME_W-1:0]   wait_val;

   assign n_jobs = (pc_ff > lsc_pkg::PC_W'(lsc_pkg::MAX_JOBS)) ?
                   lsc_pkg::NCMP_W'(lsc_pkg::MAX_JOBS) : lsc_pkg::NCMP_W'(pc_ff);
   assign cur      = idx_ff[lsc_pkg::IDX_W-1:0];
   assign load_idx = lsc_pkg::IDX_W'(slot_ff);
   assign slot_ok  = (32'(slot_ff) < 32'(lsc_pkg::MAX_JOBS));

   always_comb begin
      for (int j = 0; j < lsc_pkg::MAX_JOBS; j++) begin
         count_mask[j] = (32'(j) < 32'(n_jobs));
      end
   end

   // One restoring division step: shift in the next dividend bit, subtract if it fits.
   assign trial = {rem_ff, quo_ff[lsc_pkg::RND_W-1]};

   always_comb begin
      rem_in = rem_ff;
      if (cmd.div_init) begin
         rem_in = '0;
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, total_ff}) begin
            rem_in = lsc_pkg::TOTAL_W'(trial - {1'b0, total_ff});
         end else begin
            rem_in = trial[lsc_pkg::TOTAL_W-1:0];
         end
      end else if (cmd.scan_step && active_ff[cur]) begin
         rem_in = rem_ff - lsc_pkg::TOTAL_W'(tickets_ff[cur]);
      end
   end

   // The remainder stands for the drawn number minus one, so a slot wins on tickets above it.
   assign status.mode_draw  = (mode_ff == lsc_pkg::MODE_DRAW);
   assign status.idx_end    = (idx_ff == n_jobs);
   assign status.total_zero = (total_ff == '0);
   assign status.div_last   = (div_cnt_ff == lsc_pkg::DIVCNT_W'(lsc_pkg::RND_W - 1));
   assign status.scan_hit   = active_ff[cur] &&
                              (lsc_pkg::TOTAL_W'(tickets_ff[cur]) > rem_ff);

   assign orig_ext = lsc_pkg::TIME_W'(original_ff[cur]);
   assign wait_val = (time_ff >= orig_ext) ? (time_ff - orig_ext) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= lsc_pkg::PC_W'(1);
         time_ff      <= '0;
         remaining_ff <= '{default: '0};
         original_ff  <= '{default: '0};
         tickets_ff   <= '{default: '0};
         active_ff    <= '0;
      end else begin
         if (csr_valid) begin
            pc_ff <= csr_data;
         end
         if (cmd.load_write && slot_ok) begin
            remaining_ff[load_idx] <= burst_ff;
            original_ff[load_idx]  <= burst_ff;
            tickets_ff[load_idx]   <= load_tickets_ff;
            active_ff[load_idx]    <= (burst_ff != '0);
            time_ff                <= '0;
         end
         if (cmd.win_update) begin
            remaining_ff[cur] <= remaining_ff[cur] - lsc_pkg::BURST_W'(1);
            active_ff[cur]    <= (remaining_ff[cur] != lsc_pkg::BURST_W'(1));
            time_ff           <= time_ff + lsc_pkg::TIME_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff         <= in_mode;
         slot_ff         <= in_slot;
         burst_ff        <= in_burst;
         load_tickets_ff <= in_tickets;
         quo_ff          <= in_random_word;
         idx_ff          <= '0;
         total_ff        <= '0;
         grant_ff        <= 1'b0;
         fin_ff          <= 1'b0;
      end
      if (cmd.sum_step) begin
         if (active_ff[cur]) begin
            total_ff <= total_ff + lsc_pkg::TOTAL_W'(tickets_ff[cur]);
         end
         idx_ff <= idx_ff + lsc_pkg::NCMP_W'(1);
      end
      if (cmd.div_init) begin
         idx_ff     <= '0;
         div_cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         quo_ff     <= quo_ff << 1;
         div_cnt_ff <= div_cnt_ff + lsc_pkg::DIVCNT_W'(1);
      end
      if (cmd.scan_step) begin
         idx_ff <= idx_ff + lsc_pkg::NCMP_W'(1);
      end
      rem_ff <= rem_in;
      if (cmd.win_update) begin
         grant_ff <= 1'b1;
         fin_ff   <= (remaining_ff[cur] == lsc_pkg::BURST_W'(1));
      end
      if (cmd.out_load) begin
         out_granted         <= grant_ff;
         out_winner          <= grant_ff ? lsc_pkg::SLOT_W'(cur) : '0;
         out_finished        <= fin_ff;
         out_completion_time <= fin_ff ? time_ff : '0;
         out_waiting_time    <= fin_ff ? wait_val : '0;
         out_turnaround_time <= fin_ff ? time_ff : '0;
         out_all_done        <= ~|(active_ff & count_mask);
      end
   end

endmodule

>>> sv/lottery_scheduler_core.sv
// Top level of the ticket-weighted lottery scheduler.
//
//   Channel  Direction  Handshake              Contents
//   req      in         req_tvalid/req_tready  tuser: mode; tdata: slot, burst, tickets, word
//   rsp      out        rsp_tvalid/rsp_tready  tdata: grant, winner, finish, times, all_done
//   csr      in         csr_valid/csr_ready    process_count
//
// A load item passes capture, the mode check, the table write and the result. A draw ends
// after the ticket sum scan when no unfinished job holds tickets, and otherwise passes
// the ticket sum scan, the 16-step restoring divider, the winner scan and the update.
// Reset is synchronous and clears the job table, the clock and the process count to one.
// A finished result waits in the output register while the next item is accepted; a new
// result is held back only while that register is still full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lottery_scheduler_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lsc_pkg::REQ_DATA_W-1:0]     req_tdata,  // slot, burst, tickets, random_word
   input  logic                               req_tuser,  // mode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // granted, winner, finished, completion_time, waiting_time, turnaround_time, all_done
   output logic [lsc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lsc_pkg::PC_W-1:0]           csr_data
);

   lsc_pkg::cmd_type    cmd;
   lsc_pkg::status_type status;

   logic                        out_granted;
   logic [lsc_pkg::SLOT_W-1:0]  out_winner;
   logic                        out_finished;
   logic [lsc_pkg::TIME_W-1:0]  out_completion_time;
   logic [lsc_pkg::TIME_W-1:0]  out_waiting_time;
   logic [lsc_pkg::TIME_W-1:0]  out_turnaround_time;
   logic                        out_all_done;

   assign csr_ready = 1'b1;

   lsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lsc_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid && csr_ready),
      .csr_data            (csr_data),
      .in_mode             (req_tuser),
      .in_slot             (req_tdata[3:0]),
      .in_burst            (req_tdata[19:4]),
      .in_tickets          (req_tdata[29:20]),
      .in_random_word      (req_tdata[45:30]),
      .cmd                 (cmd),
      .status              (status),
      .out_granted         (out_granted),
      .out_winner          (out_winner),
      .out_finished        (out_finished),
      .out_completion_time (out_completion_time),
      .out_waiting_time    (out_waiting_time),
      .out_turnaround_time (out_turnaround_time),
      .out_all_done        (out_all_done)
   );

   assign rsp_tdata = {1'b0, out_all_done, out_turnaround_time, out_waiting_time,
                       out_completion_time, out_finished, out_winner, out_granted};

   // A result without a grant carries no winner and no finish.
   `ASSERT_CLK(a_no_grant_empty, !(rsp_tvalid && !rsp_tdata[0]) || (rsp_tdata[5:1] == '0), "result without grant carries a winner or finish")

   // A finished job reports equal completion and turnaround, and waiting no larger.
   `ASSERT_CLK(a_finish_times, !(rsp_tvalid && rsp_tdata[5]) || ((rsp_tdata[101:70] == rsp_tdata[37:6]) && (rsp_tdata[69:38] <= rsp_tdata[37:6])), "finished job times inconsistent")

   // One item is worked on at a time.
   `ASSERT_NEXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready, "item accepted while another is in work")

endmodule
